@@ hdl/uart_rm_pkg.sv @@
// ----------------------------------------------------------------------------
// uart_rm_pkg
// Shared types, register indexes and status flags of the UART register model.
// ----------------------------------------------------------------------------
package uart_rm_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    localparam int NUM_REGS = 12;

    localparam logic [3:0] IDX_CR1 = 4'd0;
    localparam logic [3:0] IDX_RQR = 4'd6;
    localparam logic [3:0] IDX_ISR = 4'd7;
    localparam logic [3:0] IDX_ICR = 4'd8;
    localparam logic [3:0] IDX_RDR = 4'd9;
    localparam logic [3:0] IDX_TDR = 4'd10;
    localparam logic [3:0] IDX_LIMIT = 4'd12;

    localparam int BIT_IDLE  = 4;
    localparam int BIT_RXNE  = 5;
    localparam int BIT_TC    = 6;
    localparam int BIT_TXE   = 7;
    localparam int BIT_TEACK = 21;
    localparam int BIT_REACK = 22;
    localparam int BIT_TXFE  = 23;
    localparam int BIT_FLUSH = 3;

    localparam logic [31:0] ISR_RESET = 32'h0080_00C0;
    localparam logic [31:0] IRQ_MASK  = 32'h0000_00F0;
    localparam logic [15:0] GAP_RESET = 16'd100;

    typedef struct packed {
        op_t         op;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [7:0] data;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } fifo_stat_t;

    // Refresh the derived ISR flags from CR1 and the FIFO state.
    function automatic logic [31:0] status_fn(input logic [31:0] isr,
                                              input logic [31:0] cr1,
                                              input logic        fifo_empty);
        logic [31:0] s;
        s = isr;
        s[BIT_TC]    = 1'b1;
        s[BIT_TXE]   = 1'b1;
        s[BIT_TXFE]  = 1'b1;
        s[BIT_RXNE]  = ~fifo_empty;
        s[BIT_TEACK] = cr1[0] & cr1[3];
        s[BIT_REACK] = cr1[0] & cr1[2];
        return s;
    endfunction

endpackage

@@ hdl/uart_rm_fifo.sv @@
// ----------------------------------------------------------------------------
// uart_rm_fifo
// Receive byte FIFO with a prefetched, registered head read.
// ----------------------------------------------------------------------------
module uart_rm_fifo import uart_rm_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  fifo_ctl_t  ctl,
    output fifo_stat_t stat,
    output logic [7:0] head_data
);

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CNT_W = $clog2(RX_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RX_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RX_DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(RX_DEPTH);

    logic [7:0]       mem [RX_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       rd_data_reg;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic             push_ok, pop_ok;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.last  = (count_reg == CNT_W'(1));

    assign push_ok = ctl.push & ~stat.full;
    assign pop_ok  = ctl.pop & ~stat.empty;

    always_comb begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_DEPTH) begin
            tail_sum = tail_sum - SUM_DEPTH;
        end
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.flush) begin
            head_next  = '0;
            count_next = '0;
        end else if (push_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_ok) begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed byte; prefetch the next head with write bypass.
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[tail] <= ctl.data;
        end
        if (push_ok && (tail == head_next)) begin
            rd_data_reg <= ctl.data;
        end else begin
            rd_data_reg <= mem[head_next];
        end
    end

    assign head_data = rd_data_reg;

endmodule

@@ hdl/uart_rm_core.sv @@
// ----------------------------------------------------------------------------
// uart_rm_core
// Register file, status flags and idle countdown; one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module uart_rm_core import uart_rm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        fire,
    input  item_t       item,
    input  fifo_stat_t  fifo_stat,
    input  logic [7:0]  fifo_head,
    output fifo_ctl_t   fifo_ctl,
    output result_t     result
);

    logic [31:0] reg_file_reg  [NUM_REGS];
    logic [31:0] reg_file_next [NUM_REGS];
    logic [15:0] gap_reg;
    logic [15:0] countdown_reg, countdown_next;
    logic        armed_reg, armed_next;
    logic [15:0] gap_eff;
    logic        do_status, do_rearm, rd_isr, empty_after;
    logic [31:0] rdr_val;

    assign gap_eff = (gap_reg == '0) ? 16'd1 : gap_reg;

    always_comb begin
        reg_file_next  = reg_file_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        fifo_ctl       = '0;
        result         = '0;
        do_status      = 1'b0;
        do_rearm       = 1'b0;
        rd_isr         = 1'b0;
        rdr_val        = '0;
        fifo_ctl.data  = item.rx_byte;

        case (item.op)
            OP_READ: begin
                if (item.reg_index == IDX_RDR) begin
                    fifo_ctl.pop = ~fifo_stat.empty;
                    rdr_val = fifo_stat.empty ? 32'd0 : {24'd0, fifo_head};
                    reg_file_next[IDX_RDR] = rdr_val;
                    result.read_data = rdr_val;
                    do_status = 1'b1;
                end else if (item.reg_index == IDX_ISR) begin
                    do_status = 1'b1;
                    rd_isr    = 1'b1;
                end else if (item.reg_index < IDX_LIMIT) begin
                    result.read_data = reg_file_reg[item.reg_index];
                end
            end
            OP_WRITE: begin
                if (item.reg_index < IDX_LIMIT && item.reg_index != IDX_RDR
                        && item.reg_index != IDX_ISR) begin
                    reg_file_next[item.reg_index] = item.write_data;
                    case (item.reg_index)
                        IDX_TDR: begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = item.write_data[7:0];
                            do_status = 1'b1;
                        end
                        IDX_ICR: begin
                            reg_file_next[IDX_ISR] = reg_file_reg[IDX_ISR] & ~item.write_data;
                            reg_file_next[IDX_ICR] = '0;
                            do_status = 1'b1;
                        end
                        IDX_RQR: begin
                            fifo_ctl.flush = item.write_data[BIT_FLUSH];
                            reg_file_next[IDX_RQR] = '0;
                            do_status = 1'b1;
                        end
                        IDX_CR1: begin
                            do_status = 1'b1;
                            do_rearm  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_RX: begin
                fifo_ctl.push = 1'b1;
                do_status = 1'b1;
                do_rearm  = 1'b1;
            end
            OP_TICK: begin
                if (armed_reg) begin
                    if (countdown_reg <= 16'd1) begin
                        countdown_next = '0;
                        armed_next     = 1'b0;
                        reg_file_next[IDX_ISR][BIT_IDLE] = 1'b1;
                    end else begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        // FIFO occupancy as it stands after this item
        if (fifo_ctl.flush) begin
            empty_after = 1'b1;
        end else if (fifo_ctl.push) begin
            empty_after = 1'b0;
        end else if (fifo_ctl.pop) begin
            empty_after = fifo_stat.last;
        end else begin
            empty_after = fifo_stat.empty;
        end

        if (do_status) begin
            reg_file_next[IDX_ISR] = status_fn(reg_file_next[IDX_ISR],
                                               reg_file_next[IDX_CR1], empty_after);
        end
        if (rd_isr) begin
            result.read_data = reg_file_next[IDX_ISR];
        end
        if (do_rearm) begin
            armed_next = ~empty_after;
            if (!empty_after) begin
                countdown_next = gap_eff;
            end
        end

        result.irq = |(reg_file_next[IDX_CR1] & reg_file_next[IDX_ISR] & IRQ_MASK);

        if (!fire) begin
            fifo_ctl.push  = 1'b0;
            fifo_ctl.pop   = 1'b0;
            fifo_ctl.flush = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                reg_file_reg[i] <= (i == int'(IDX_ISR)) ? ISR_RESET : '0;
            end
            gap_reg       <= GAP_RESET;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                gap_reg <= cfg_wr_data;
            end
            if (fire) begin
                reg_file_reg  <= reg_file_next;
                countdown_reg <= countdown_next;
                armed_reg     <= armed_next;
            end
        end
    end

endmodule

@@ hdl/uart_register_model.sv @@
// ----------------------------------------------------------------------------
// uart_register_model
// Register-level UART model: bus accesses, received bytes and ticks in,
// one result item per input item out.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on the s_axis channel is a bus read, a bus write, a
//   received serial byte or a time tick, selected by s_axis_tuser. Every
//   item yields exactly one result item on m_axis: read data, an optional
//   transmit byte and the interrupt level after the item.
//   Configuration: cfg_wr_en/cfg_wr_data load the idle gap (ticks after
//   receive activity before the IDLE flag sets). Write it only while idle.
//   Path: an accepted item is registered in the input register, processed by
//   the register file/FIFO logic and lands in the result register, which
//   drives m_axis_tvalid; while the result register is stalled the item waits.
//   Throughput: one item per cycle while m_axis_tready stays high; the register
//   file, the FIFO pointers and the idle counter are updated together per item.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register takes one more item only if it is empty, then s_axis_tready drops
//   until the result is taken.
//   Reset (aresetn low, synchronous): control and state clear, ISR loads
//   0x008000C0, the idle gap loads 100, the FIFO is empty. FIFO storage is
//   not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module uart_register_model import uart_rm_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // idle_gap
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // reg_index[3:0], write_data[35:4], rx_byte[43:36]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_data[31:0], tx_valid[32], tx_byte[40:33], irq[41]
);

    item_t      in_item_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       advance, fire, s_accept;
    result_t    result;
    fifo_ctl_t  fifo_ctl;
    fifo_stat_t fifo_stat;
    logic [7:0] fifo_head;

    // Move the held item forward whenever the result register is free
    assign advance       = ~out_valid_reg | m_axis_tready;
    assign fire          = in_valid_reg & advance;
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the payload; hold it while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.op         <= op_t'(s_axis_tuser);
            in_item_reg.reg_index  <= s_axis_tdata[3:0];
            in_item_reg.write_data <= s_axis_tdata[35:4];
            in_item_reg.rx_byte    <= s_axis_tdata[43:36];
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    uart_rm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (in_item_reg),
        .fifo_stat   (fifo_stat),
        .fifo_head   (fifo_head),
        .fifo_ctl    (fifo_ctl),
        .result      (result)
    );

    uart_rm_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (fifo_ctl),
        .stat      (fifo_stat),
        .head_data (fifo_head)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.irq, out_reg.tx_byte, out_reg.tx_valid,
                            out_reg.read_data};

    // Input side stalls only when both stages hold items
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // Only a bus write can emit a transmit byte
    a_tx_only_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_item_reg.op != OP_WRITE) |=> !out_reg.tx_valid)
        else $error("transmit byte without a bus write");

    // Reading RDR from an empty FIFO returns zero
    a_rdr_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_item_reg.op == OP_READ && in_item_reg.reg_index == IDX_RDR
            && fifo_stat.empty) |=> (out_reg.read_data == 32'd0))
        else $error("empty RDR read returned data");

    // A full FIFO never reports empty
    a_fifo_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.full |-> !fifo_stat.empty)
        else $error("FIFO full and empty at once");

endmodule
